@@ design/dma_channel_burst_sequencer_assert.svh @@
// assertion macros for the dma channel burst sequencer
`ifndef DMA_CHANNEL_BURST_SEQUENCER_ASSERT_SVH
`define DMA_CHANNEL_BURST_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define DCBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcbs check failed");

// next-cycle implication, checked while out of reset
`define DCBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcbs check failed");

`endif

@@ design/dcbs_pkg.sv @@
// types and constants shared by the dma channel burst sequencer
`default_nettype none
package dcbs_pkg;

    localparam int COUNT_W    = 17;
    localparam int CH_FIELD_W = 3;

    // opcodes
    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_TRIG = 2'd1;
    localparam logic [1:0] OP_CTL  = 2'd2;

    // working flag bit positions (control word bits 31..16)
    localparam int FL_DEST_LO  = 5;
    localparam int FL_SRC_LO   = 7;
    localparam int FL_REPEAT   = 9;
    localparam int FL_WIDE     = 10;
    localparam int FL_START_LO = 12;
    localparam int FL_ENABLE   = 15;
    localparam int CTL_ENABLE  = 31;

    // step modes
    localparam logic [1:0] MODE_INC    = 2'd0;
    localparam logic [1:0] MODE_DEC    = 2'd1;
    localparam logic [1:0] MODE_RELOAD = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  channel;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [31:0] control_word;
        logic [1:0]  start_type;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         burst_channel;
        logic [31:0]        source_start;
        logic [31:0]        dest_start;
        logic [COUNT_W-1:0] unit_count;
        logic               word_wide;
        logic [1:0]         source_mode;
        logic [1:0]         dest_mode;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic                  load;
        logic                  wr_ctl;
        logic                  visit;
        logic [CH_FIELD_W-1:0] sel;
        logic [1:0]            stype;
    } t_cmd;

endpackage
`default_nettype wire

@@ design/dcbs_ctrl.sv @@
// controller: decodes items and steps the channel scan
`default_nettype none
module dcbs_ctrl #(
    parameter int CHANNELS = 4,
    parameter int CH_W     = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire dcbs_pkg::t_in_item i_item,
    output logic                  busy,
    output dcbs_pkg::t_cmd        o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic            r_state, n_state;
    logic [CH_W-1:0] r_idx, n_idx;
    logic [1:0]      r_type, n_type;
    logic            accept;
    logic            ch_ok;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start & ~busy;
    assign ch_ok  = ({1'b0, i_item.channel} < 4'(CHANNELS));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_type       = r_type;
        o_cmd.load   = 1'b0;
        o_cmd.wr_ctl = 1'b0;
        o_cmd.visit  = 1'b0;
        o_cmd.sel    = i_item.channel;
        o_cmd.stype  = r_type;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.opcode)
                        dcbs_pkg::OP_SET: begin
                            if (ch_ok) begin
                                o_cmd.load = 1'b1;
                                n_state    = ST_SCAN;
                                n_idx      = '0;
                                n_type     = 2'd0;
                            end
                        end
                        dcbs_pkg::OP_TRIG: begin
                            n_state = ST_SCAN;
                            n_idx   = '0;
                            n_type  = i_item.start_type;
                        end
                        dcbs_pkg::OP_CTL: begin
                            o_cmd.wr_ctl = ch_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.visit = 1'b1;
                o_cmd.sel   = dcbs_pkg::CH_FIELD_W'(r_idx);
                if (r_idx == CH_W'(CHANNELS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_type  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_type  <= n_type;
        end
    end

endmodule
`default_nettype wire

@@ design/dcbs_datapath.sv @@
// datapath: channel state, per-channel burst step and result register
`default_nettype none
module dcbs_datapath #(
    parameter int CHANNELS = 4,
    parameter int CH_W     = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dcbs_pkg::t_cmd     i_cmd,
    input  wire dcbs_pkg::t_in_item i_item,
    output logic                    o_strobe,
    output dcbs_pkg::t_out_item     o_result
);

    localparam int CW = dcbs_pkg::COUNT_W;

    logic [31:0]   r_sh_dst [CHANNELS];
    logic [31:0]   r_sh_ctl [CHANNELS];
    logic [31:0]   r_wk_src [CHANNELS];
    logic [31:0]   r_wk_dst [CHANNELS];
    logic [CW-1:0] r_wk_cnt [CHANNELS];
    logic [15:0]   r_wk_flg [CHANNELS];

    logic                r_strobe;
    dcbs_pkg::t_out_item r_result;

    logic [CH_W-1:0] sel;
    logic [31:0]     c_src, c_dst, c_shctl, c_shdst;
    logic [CW-1:0]   c_cnt;
    logic [15:0]     c_flg;
    logic [1:0]      dm, sm;
    logic            match, zero_addr, emit, hi_emit;
    logic [31:0]     bytes;
    logic [31:0]     n_src, n_dst;
    logic [CW-1:0]   n_cnt;
    logic [15:0]     n_flg;
    logic [CHANNELS-1:0] pred;
    logic [2:0]      sel3;

    assign sel     = i_cmd.sel[CH_W-1:0];
    assign sel3    = 3'(sel);
    assign c_src   = r_wk_src[sel];
    assign c_dst   = r_wk_dst[sel];
    assign c_cnt   = r_wk_cnt[sel];
    assign c_flg   = r_wk_flg[sel];
    assign c_shctl = r_sh_ctl[sel];
    assign c_shdst = r_sh_dst[sel];
    assign dm      = c_flg[dcbs_pkg::FL_DEST_LO +: 2];
    assign sm      = c_flg[dcbs_pkg::FL_SRC_LO +: 2];

    // channel visit: enable check, fire test, address step
    always_comb begin
        match     = c_shctl[dcbs_pkg::CTL_ENABLE] & c_flg[dcbs_pkg::FL_ENABLE]
                    & (c_flg[dcbs_pkg::FL_START_LO +: 2] == i_cmd.stype);
        zero_addr = (c_src == '0) | (c_dst == '0);
        emit      = match & ~zero_addr;
        bytes     = c_flg[dcbs_pkg::FL_WIDE] ? {13'd0, c_cnt, 2'b00}
                                             : {14'd0, c_cnt, 1'b0};
        n_src = c_src;
        n_dst = c_dst;
        n_cnt = c_cnt;
        n_flg = c_flg;
        if (!c_shctl[dcbs_pkg::CTL_ENABLE]) begin
            n_flg[dcbs_pkg::FL_ENABLE] = 1'b0;
        end
        if (match & zero_addr) begin
            n_flg[dcbs_pkg::FL_ENABLE] = 1'b0;
        end
        if (emit) begin
            if (dm == dcbs_pkg::MODE_INC || dm == dcbs_pkg::MODE_RELOAD) begin
                n_dst = c_dst + bytes;
            end else if (dm == dcbs_pkg::MODE_DEC) begin
                n_dst = c_dst - bytes;
            end
            if (sm == dcbs_pkg::MODE_INC) begin
                n_src = c_src + bytes;
            end else if (sm == dcbs_pkg::MODE_DEC) begin
                n_src = c_src - bytes;
            end
            if (c_flg[dcbs_pkg::FL_REPEAT]) begin
                n_cnt = c_shctl[CW-1:0];
                if (dm == dcbs_pkg::MODE_RELOAD) begin
                    n_dst = c_shdst;
                end
            end else begin
                n_flg[dcbs_pkg::FL_ENABLE] = 1'b0;
            end
        end
    end

    // a higher channel that will still fire makes this burst not the last one
    always_comb begin
        hi_emit = 1'b0;
        for (int j = 0; j < CHANNELS; j++) begin
            pred[j] = r_sh_ctl[j][dcbs_pkg::CTL_ENABLE]
                      & r_wk_flg[j][dcbs_pkg::FL_ENABLE]
                      & (r_wk_flg[j][dcbs_pkg::FL_START_LO +: 2] == i_cmd.stype)
                      & (r_wk_src[j] != '0) & (r_wk_dst[j] != '0);
            if (j > int'(sel)) begin
                hi_emit = hi_emit | pred[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < CHANNELS; j++) begin
                r_sh_dst[j] <= '0;
                r_sh_ctl[j] <= '0;
                r_wk_src[j] <= '0;
                r_wk_dst[j] <= '0;
                r_wk_cnt[j] <= '0;
                r_wk_flg[j] <= '0;
            end
        end else begin
            for (int j = 0; j < CHANNELS; j++) begin
                if (int'(sel) == j) begin
                    if (i_cmd.load) begin
                        r_sh_dst[j] <= i_item.dest_addr;
                        r_sh_ctl[j] <= i_item.control_word;
                        r_wk_src[j] <= i_item.source_addr;
                        r_wk_dst[j] <= i_item.dest_addr;
                        r_wk_cnt[j] <= i_item.control_word[CW-1:0];
                        r_wk_flg[j] <= i_item.control_word[31:16];
                    end else if (i_cmd.wr_ctl) begin
                        r_sh_ctl[j] <= i_item.control_word;
                    end else if (i_cmd.visit) begin
                        r_wk_src[j] <= n_src;
                        r_wk_dst[j] <= n_dst;
                        r_wk_cnt[j] <= n_cnt;
                        r_wk_flg[j] <= n_flg;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.visit & emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.visit & emit) begin
            r_result.burst_channel <= sel3[1:0];
            r_result.source_start  <= c_src;
            r_result.dest_start    <= c_dst;
            r_result.unit_count    <= c_cnt;
            r_result.word_wide     <= c_flg[dcbs_pkg::FL_WIDE];
            r_result.source_mode   <= sm;
            r_result.dest_mode     <= dm;
            r_result.last          <= ~hi_emit;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

@@ design/dma_channel_burst_sequencer.sv @@
// top level of the dma channel burst sequencer
// set channel items with a valid channel and trigger items are decoded, then each channel is
// visited in a scan, lowest channel first; a control shadow write does not start a scan.
// a burst descriptor appears on o_result with o_strobe in the cycle after its channel is visited.
// busy is high for the whole scan; the per-channel step is the rate limit.
// synchronous active-low reset clears all channel state, so every channel starts disabled.
`default_nettype none
module dma_channel_burst_sequencer #(
    parameter int CHANNELS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire dcbs_pkg::t_in_item i_item,
    output logic                    busy,
    output logic                    o_strobe,
    output dcbs_pkg::t_out_item     o_result
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    dcbs_pkg::t_cmd cmd;

    dcbs_ctrl #(
        .CHANNELS(CHANNELS),
        .CH_W    (CH_W)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_item (i_item),
        .busy   (busy),
        .o_cmd  (cmd)
    );

    dcbs_datapath #(
        .CHANNELS(CHANNELS),
        .CH_W    (CH_W)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule
`default_nettype wire

@@ design/dcbs_checker.sv @@
// port-level checks for the dma channel burst sequencer and their bind
`default_nettype none
`include "dma_channel_burst_sequencer_assert.svh"
module dcbs_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire dcbs_pkg::t_in_item  i_item,
    input wire logic                busy,
    input wire logic                o_strobe,
    input wire dcbs_pkg::t_out_item o_result
);

    logic ctl_taken;
    logic trig_taken;

    assign ctl_taken  = start && !busy && i_item.opcode == dcbs_pkg::OP_CTL;
    assign trig_taken = start && !busy && i_item.opcode == dcbs_pkg::OP_TRIG;

    // a burst only comes out of a scan
    `DCBS_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))
    // a control shadow write never starts a scan
    `DCBS_ASSERT_NEXT(a_ctl_no_scan, i_clk, i_rst_n, ctl_taken, !busy)
    // a trigger always starts a scan
    `DCBS_ASSERT_NEXT(a_trig_scans, i_clk, i_rst_n, trig_taken, busy)
    // nothing follows the last burst of an item directly
    `DCBS_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_strobe && o_result.last, !o_strobe)

endmodule

bind dma_channel_burst_sequencer dcbs_checker u_dcbs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_item  (i_item),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);
`default_nettype wire
